// ===== rtl/ghp_pkg.sv =====
// ----------------------------------------------------------------------------
// ghp_pkg
// Shared types and constants of the generational handle pool: handle layout,
// field widths, result status codes, request kinds and register indexes.
// ----------------------------------------------------------------------------
package ghp_pkg;

    // Handle layout: index in the low half, generation in the high half
    localparam int IDX_W    = 16;
    localparam int GEN_W    = 16;
    localparam int HANDLE_W = IDX_W + GEN_W;

    // Register and count widths
    localparam int ACTIVE_W = 17;
    localparam int FREE_W   = 17;
    localparam int CFG_AW   = 2;

    // Stream payload widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_STALE     = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    // Request kinds
    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_ACTIVE_SLOTS = 2'd0,
        CFG_FIRST_GEN    = 2'd1
    } t_cfg_reg;

endpackage

// ===== rtl/ghp_ram.sv =====
// ----------------------------------------------------------------------------
// ghp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// The read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module ghp_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/generational_handle_pool.sv =====
// ----------------------------------------------------------------------------
// generational_handle_pool
// Slot allocator handing out 32-bit handles (generation:index). Free slots
// wait in a ring RAM with a free count; a slot table RAM keeps each slot's
// busy mark and generation. Allocate pops the ring, free checks and pushes.
// ----------------------------------------------------------------------------
//
//  channel  | direction | fields (low bit up)                  | accepted when
//  ---------+-----------+--------------------------------------+-----------------------
//  s_axis   | in        | tuser: action; tdata: handle_in      | tvalid & tready
//  m_axis   | out       | tuser: status; tdata: handle_out,    | tvalid & tready
//           |           |   free_slots                         |
//  cfg      | in        | addr: register index; wdata: value   | i_cfg_we
//
//  One item per cycle while m_axis keeps up. An accepted item reads the ring and
//  slot table at the accepting edge into the work stage, then moves on into the
//  output register, which drives m_axis_tvalid; hazards between back-to-back
//  items are forwarded around the RAMs. After reset and after each active_slots
//  write, a clearing pass over the used slots holds s_axis_tready low. A stalled
//  m_axis holds the stage.
// ----------------------------------------------------------------------------
module generational_handle_pool #(
    parameter int POOL_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ghp_pkg::S_TDATA_W-1:0]       s_axis_tdata,  // [31:0] handle_in
    input  logic                                s_axis_tuser,  // [0] action
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ghp_pkg::M_TDATA_W-1:0]       m_axis_tdata,  // [31:0] handle_out,
                                                               // [48:32] free_slots
    output logic [ghp_pkg::M_TUSER_W-1:0]       m_axis_tuser,  // [1:0] status
    // configuration
    input  logic                                i_cfg_we,
    input  logic [ghp_pkg::CFG_AW-1:0]          i_cfg_addr,
    input  logic [ghp_pkg::ACTIVE_W-1:0]        i_cfg_wdata
);

    localparam int IW     = $clog2(POOL_DEPTH);
    localparam int CW     = $clog2(POOL_DEPTH + 1);
    localparam int RING_W = ghp_pkg::GEN_W + IW;
    localparam int SLOT_W = ghp_pkg::GEN_W + 1;
    localparam logic [ghp_pkg::ACTIVE_W-1:0] RESET_ACTIVE = 17'd256;
    localparam logic [ghp_pkg::GEN_W-1:0]    RESET_GEN    = 16'd1;

    // Clamp a written size into 1..POOL_DEPTH
    function automatic logic [CW-1:0] clamp_size(input logic [ghp_pkg::ACTIVE_W-1:0] v);
        logic [CW-1:0] res;
        if (v == '0) begin
            res = CW'(1);
        end else if ({1'b0, v} > 18'(POOL_DEPTH)) begin
            res = CW'(POOL_DEPTH);
        end else begin
            res = CW'(v);
        end
        return res;
    endfunction

    // Ring position step with wrap at the used size
    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p,
                                                input logic [CW-1:0] used);
        logic [IW:0] p1;
        p1 = {1'b0, p} + (IW+1)'(1);
        return (p1 >= (IW+1)'(used)) ? '0 : p1[IW-1:0];
    endfunction

    // Configuration and pool control state
    logic [CW-1:0]                r_used;
    logic [ghp_pkg::GEN_W-1:0]    r_first_gen;
    logic [ghp_pkg::GEN_W-1:0]    r_init_gen;
    logic                         r_clr_busy;
    logic [IW-1:0]                r_clr_ptr;
    logic [IW-1:0]                r_head, n_head;
    logic [IW-1:0]                r_tail, n_tail;
    logic [CW-1:0]                r_count, n_count;

    // Work stage
    logic                         r_s1_valid;
    ghp_pkg::t_action             r_s1_action;
    logic [ghp_pkg::HANDLE_W-1:0] r_s1_handle;
    logic                         s1_fire;

    // Forwarding around the RAMs
    logic                         r_ring_byp;
    logic [RING_W-1:0]            r_ring_byp_data;
    logic                         r_slot_byp;
    logic [SLOT_W-1:0]            r_slot_byp_data;

    // Output register
    logic                         r_out_valid;
    ghp_pkg::t_status             r_out_status;
    logic [ghp_pkg::HANDLE_W-1:0] r_out_handle;
    logic [CW-1:0]                r_out_free;

    // RAM ports
    logic                         accept;
    logic [RING_W-1:0]            ring_rdata, ring_q;
    logic [SLOT_W-1:0]            slot_rdata, slot_q;
    logic                         ring_we, slot_we;
    logic [IW-1:0]                ring_waddr, slot_waddr;
    logic [RING_W-1:0]            ring_wdata;
    logic [SLOT_W-1:0]            slot_wdata;
    logic [IW-1:0]                slot_raddr;

    // Stage results
    ghp_pkg::t_status             s1_status;
    logic [ghp_pkg::HANDLE_W-1:0] s1_handle_out;
    logic                         push_we, s1_slot_we;
    logic [RING_W-1:0]            push_data;
    logic [IW-1:0]                s1_slot_addr;
    logic [SLOT_W-1:0]            s1_slot_data;

    logic                         cfg_size_wr;
    logic                         clr_last;

    // Handshakes
    assign s1_fire       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_clr_busy && (!r_s1_valid || s1_fire);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_size_wr   = i_cfg_we && (i_cfg_addr == ghp_pkg::CFG_ACTIVE_SLOTS);
    assign clr_last      = (({1'b0, r_clr_ptr} + (IW+1)'(1)) >= (IW+1)'(r_used));

    // Forwarded RAM data
    assign ring_q = r_ring_byp ? r_ring_byp_data : ring_rdata;
    assign slot_q = r_slot_byp ? r_slot_byp_data : slot_rdata;

    // Resolve the staged item
    always_comb begin
        logic [IW-1:0]              idx;
        logic [ghp_pkg::GEN_W-1:0]  gen;
        logic [ghp_pkg::IDX_W-1:0]  hidx;
        logic [ghp_pkg::GEN_W-1:0]  hgen;
        logic [ghp_pkg::GEN_W-1:0]  bumped;
        s1_status     = ghp_pkg::ST_OK;
        s1_handle_out = '0;
        push_we       = 1'b0;
        push_data     = '0;
        s1_slot_we    = 1'b0;
        s1_slot_addr  = '0;
        s1_slot_data  = '0;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        idx           = ring_q[IW-1:0];
        gen           = ring_q[RING_W-1:IW];
        hidx          = r_s1_handle[ghp_pkg::IDX_W-1:0];
        hgen          = r_s1_handle[ghp_pkg::HANDLE_W-1:ghp_pkg::IDX_W];
        bumped        = slot_q[ghp_pkg::GEN_W-1:0] + ghp_pkg::GEN_W'(1);
        if (r_s1_valid) begin
            unique case (r_s1_action)
                ghp_pkg::ACT_ALLOC: begin
                    if (r_count == '0) begin
                        s1_status = ghp_pkg::ST_EXHAUSTED;
                    end else begin
                        s1_handle_out = {gen, ghp_pkg::IDX_W'(idx)};
                        s1_slot_we    = s1_fire;
                        s1_slot_addr  = idx;
                        s1_slot_data  = {1'b1, gen};
                        if (s1_fire) begin
                            n_head  = ring_next(r_head, r_used);
                            n_count = r_count - CW'(1);
                        end
                    end
                end
                ghp_pkg::ACT_FREE: begin
                    if ({1'b0, hidx} >= (ghp_pkg::IDX_W+1)'(r_used)) begin
                        s1_status = ghp_pkg::ST_RANGE;
                    end else if (!slot_q[ghp_pkg::GEN_W] ||
                                 (slot_q[ghp_pkg::GEN_W-1:0] != hgen)) begin
                        s1_status = ghp_pkg::ST_STALE;
                    end else begin
                        s1_slot_we   = s1_fire;
                        s1_slot_addr = hidx[IW-1:0];
                        s1_slot_data = {1'b0, bumped};
                        if (s1_fire && (r_count < r_used)) begin
                            push_we   = 1'b1;
                            push_data = {bumped, hidx[IW-1:0]};
                            n_tail    = ring_next(r_tail, r_used);
                            n_count   = r_count + CW'(1);
                        end
                    end
                end
                default: begin
                    s1_status = ghp_pkg::ST_OK;
                end
            endcase
        end
    end

    // RAM write muxes: clearing pass or stage writes
    always_comb begin
        if (r_clr_busy) begin
            ring_we    = 1'b1;
            ring_waddr = r_clr_ptr;
            ring_wdata = {r_init_gen, r_clr_ptr};
            slot_we    = 1'b1;
            slot_waddr = r_clr_ptr;
            slot_wdata = {1'b0, r_init_gen};
        end else begin
            ring_we    = push_we;
            ring_waddr = r_tail;
            ring_wdata = push_data;
            slot_we    = s1_slot_we;
            slot_waddr = s1_slot_addr;
            slot_wdata = s1_slot_data;
        end
    end

    assign slot_raddr = s_axis_tdata[IW-1:0];

    ghp_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (RING_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_re    (accept),
        .i_raddr (n_head),
        .o_rdata (ring_rdata)
    );

    ghp_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (SLOT_W)
    ) u_slot (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (accept),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // Capture forwarding data when the stage writes what the new item reads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring_byp      <= ring_we && (ring_waddr == n_head);
            r_ring_byp_data <= ring_wdata;
            r_slot_byp      <= slot_we && (slot_waddr == slot_raddr);
            r_slot_byp_data <= slot_wdata;
        end
    end

    // Configuration, clearing pass and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= clamp_size(RESET_ACTIVE);
            r_count     <= clamp_size(RESET_ACTIVE);
            r_first_gen <= RESET_GEN;
            r_init_gen  <= RESET_GEN;
            r_clr_busy  <= 1'b1;
            r_clr_ptr   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
        end else if (cfg_size_wr) begin
            r_used     <= clamp_size(i_cfg_wdata);
            r_count    <= clamp_size(i_cfg_wdata);
            r_init_gen <= r_first_gen;
            r_clr_busy <= 1'b1;
            r_clr_ptr  <= '0;
            r_head     <= '0;
            r_tail     <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_addr == ghp_pkg::CFG_FIRST_GEN)) begin
                r_first_gen <= i_cfg_wdata[ghp_pkg::GEN_W-1:0];
            end
            if (r_clr_busy) begin
                r_clr_ptr <= r_clr_ptr + IW'(1);
                if (clr_last) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Advance the work stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_action <= ghp_pkg::t_action'(s_axis_tuser);
            r_s1_handle <= s_axis_tdata[ghp_pkg::HANDLE_W-1:0];
        end
    end

    // Output register: load on stage fire, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_status <= s1_status;
            r_out_handle <= s1_handle_out;
            r_out_free   <= n_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {
        (ghp_pkg::M_TDATA_W - ghp_pkg::HANDLE_W - ghp_pkg::FREE_W)'(0),
        ghp_pkg::FREE_W'(r_out_free),
        r_out_handle
    };

endmodule

// ===== rtl/ghp_checker.sv =====
// ----------------------------------------------------------------------------
// ghp_checker
// Port-level checks of the generational handle pool, bound to the top level.
// ----------------------------------------------------------------------------
module ghp_checker #(
    parameter int POOL_DEPTH = 256
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [ghp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [ghp_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    logic [ghp_pkg::HANDLE_W-1:0] handle_out;
    logic [ghp_pkg::FREE_W-1:0]   free_slots;

    assign handle_out = m_axis_tdata[ghp_pkg::HANDLE_W-1:0];
    assign free_slots = m_axis_tdata[ghp_pkg::HANDLE_W +: ghp_pkg::FREE_W];

    // Free count never exceeds the pool
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ({1'b0, free_slots} <= 18'(POOL_DEPTH)))
        else $error("free_slots above pool depth");

    // Failed requests return a zero handle
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ghp_pkg::ST_OK)) |-> (handle_out == '0))
        else $error("nonzero handle on a failed request");

    // Exhaustion only with an empty pool
    a_exhausted_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ghp_pkg::ST_EXHAUSTED)) |-> (free_slots == '0))
        else $error("exhausted with free slots left");

    // Handed-out index lies inside the pool
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ghp_pkg::ST_OK) && (handle_out != '0)) |->
        ({1'b0, handle_out[ghp_pkg::IDX_W-1:0]} < 17'(POOL_DEPTH)))
        else $error("handle index outside the pool");

    // Clearing pass blocks requests right after reset
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("request accepted during the clearing pass");

endmodule

bind generational_handle_pool ghp_checker #(
    .POOL_DEPTH (POOL_DEPTH)
) u_ghp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
